### hdl/tts_pkg.sv
// Shared types and codes of the timer task scheduler.
package tts_pkg;

  typedef enum logic [1:0] {
    MODE_DUE,
    MODE_FREE,
    MODE_ID
  } mode_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRE,
    OP_FREE
  } op_e;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ONCE   = 2'd1;
  localparam logic [1:0] KIND_REP    = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  localparam logic [2:0] RES_SCHED    = 3'd0;
  localparam logic [2:0] RES_FULL     = 3'd1;
  localparam logic [2:0] RES_FIRED    = 3'd2;
  localparam logic [2:0] RES_CANCEL   = 3'd3;
  localparam logic [2:0] RES_NOTFOUND = 3'd4;

  localparam logic [30:0] FIRST_ID = 31'd42;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;

  // state broadcast to every cell
  typedef struct packed {
    mode_e        mode;
    logic [63:0]  now;
    logic [30:0]  cid;
    logic [31:0]  icnt;
  } bcast_t;

  // slot contents written on schedule
  typedef struct packed {
    logic [30:0]  id;
    logic [63:0]  target;
    logic [31:0]  period;
    logic [15:0]  tag;
  } load_t;

  // best candidate handed from cell to cell
  typedef struct packed {
    logic         valid;
    logic         rep;
    logic [30:0]  id;
    logic [15:0]  tag;
    logic [63:0]  target;
    logic [31:0]  age;
  } tok_t;

endpackage

### hdl/tts_cell.sv
// One timer slot and its stage of the candidate chain.
module tts_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tts_pkg::bcast_t bc_i,
  input  tts_pkg::op_e    op_i,
  input  logic [IW-1:0]   op_idx_i,
  input  tts_pkg::load_t  ld_i,
  input  tts_pkg::tok_t   tok_i,
  input  logic [IW-1:0]   idx_i,
  output tts_pkg::tok_t   tok_o,
  output logic [IW-1:0]   idx_o
);
  import tts_pkg::*;

  logic        busy_q, busy_d;
  logic [30:0] id_q;
  logic [63:0] target_q;
  logic [31:0] period_q;
  logic [15:0] tag_q;
  logic [31:0] order_q;
  logic [31:0] age;
  logic        sel;
  logic        hit;
  tok_t        own;

  assign hit = (op_idx_i == IW'(IDX));
  assign age = bc_i.icnt - order_q;

  always_comb begin
    own.valid  = 1'b1;
    own.rep    = (period_q != 32'd0);
    own.id     = id_q;
    own.tag    = tag_q;
    own.target = target_q;
    own.age    = age;
  end

  always_comb begin
    sel = 1'b0;
    unique case (bc_i.mode)
      MODE_DUE: begin
        sel = busy_q && (target_q <= bc_i.now) &&
              (!tok_i.valid || (target_q < tok_i.target) ||
               ((target_q == tok_i.target) && (age > tok_i.age)));
      end
      MODE_FREE: sel = !busy_q && !tok_i.valid;
      MODE_ID:   sel = busy_q && (id_q == bc_i.cid) && !tok_i.valid;
      default:   sel = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (hit) begin
      case (op_i)
        OP_LOAD: busy_d = 1'b1;
        OP_FIRE: busy_d = (period_q != 32'd0);
        OP_FREE: busy_d = 1'b0;
        default: busy_d = busy_q;
      endcase
    end
  end

  // pass the better candidate on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tok_o  <= '0;
      idx_o  <= '0;
    end else begin
      busy_q       <= busy_d;
      tok_o.valid  <= sel ? 1'b1       : tok_i.valid;
      tok_o.rep    <= sel ? own.rep    : tok_i.rep;
      tok_o.id     <= sel ? own.id     : tok_i.id;
      tok_o.tag    <= sel ? own.tag    : tok_i.tag;
      tok_o.target <= sel ? own.target : tok_i.target;
      tok_o.age    <= sel ? own.age    : tok_i.age;
      idx_o        <= sel ? IW'(IDX)   : idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && op_i == OP_LOAD) begin
      id_q     <= ld_i.id;
      target_q <= ld_i.target;
      period_q <= ld_i.period;
      tag_q    <= ld_i.tag;
      order_q  <= bc_i.icnt;
    end else if (hit && op_i == OP_FIRE) begin
      target_q <= target_q + {32'd0, period_q};
      order_q  <= bc_i.icnt;
    end
  end

endmodule

### hdl/timer_task_scheduler_unit.sv
// Top level: microsecond clock, slot chain, fire buffer and result register.
// Each search passes through the SLOTS-cell chain.
// Schedule and cancel: one search, then the result word is loaded once the output is free.
// Tick: one search per fire plus one more, then each fire result passes through ST_RD and ST_WR.
// Reset clears the clock, busy flags and insert counter and sets the id counter to FIRST_ID at once;
// no clearing pass is needed.
module timer_task_scheduler_unit #(
  parameter int SLOTS     = 16,
  parameter int MAX_FIRES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i,     // tick_period_us
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [79:0]   s_axis_tdata,   // delay_us[31:0], tag[47:32], cancel_id[78:48]
  input  logic [1:0]    s_axis_tuser,   // kind[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // task_id[30:0], tag_out[46:31],
                                        // fire_target[110:47], more_due[111]
  output logic [2:0]    m_axis_tuser,   // result_kind[2:0]
  output logic          m_axis_tlast    // last
);
  import tts_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;
  localparam int NW = $clog2(MAX_FIRES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] nfire_q, nfire_d;
  logic [NW-1:0] rd_q, rd_d;
  logic          more_q, more_d;
  logic [15:0]   per_q;
  logic [63:0]   now_q, now_d;
  logic [30:0]   nid_q, nid_d;
  logic [31:0]   icnt_q, icnt_d;
  mode_e         mode_q, mode_d;
  logic [1:0]    kind_q;
  logic [31:0]   delay_q;
  logic [15:0]   tag_q;
  logic [30:0]   cid_q;

  logic          out_valid_q, out_valid_d;
  logic [111:0]  out_data_q, out_data_d;
  logic [2:0]    out_user_q, out_user_d;
  logic          out_last_q, out_last_d;
  logic          out_free;
  logic          in_acc;
  logic          scan_done;
  logic          buf_we;
  logic [110:0]  mem [MAX_FIRES];
  logic [110:0]  rdata_q;
  logic [30:0]   nid_inc;

  bcast_t        bc;
  load_t         ld;
  op_e           op;
  logic [IW-1:0] op_idx;
  tok_t          tok [SLOTS+1];
  logic [IW-1:0] tix [SLOTS+1];
  tok_t          win;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign scan_done     = (state_q == ST_SCAN) && (cnt_q == CW'(SLOTS));
  assign win           = tok[SLOTS];
  assign nid_inc       = nid_q + 31'd1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    bc.mode = mode_q;
    bc.now  = now_q;
    bc.cid  = cid_q;
    bc.icnt = icnt_q;
    ld.id     = nid_q;
    ld.target = now_q + {32'd0, delay_q};
    ld.period = (kind_q == KIND_REP) ? delay_q : 32'd0;
    ld.tag    = tag_q;
  end

  assign tok[0] = '0;
  assign tix[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tts_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .bc_i     (bc),
      .op_i     (op),
      .op_idx_i (op_idx),
      .ld_i     (ld),
      .tok_i    (tok[g]),
      .idx_i    (tix[g]),
      .tok_o    (tok[g+1]),
      .idx_o    (tix[g+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = (cnt_q == CW'(SLOTS)) ? cnt_q : cnt_q + CW'(1);
    nfire_d     = nfire_q;
    rd_d        = rd_q;
    more_d      = more_q;
    now_d       = now_q;
    nid_d       = nid_q;
    icnt_d      = icnt_q;
    mode_d      = mode_q;
    op          = OP_NONE;
    op_idx      = tix[SLOTS];
    buf_we      = 1'b0;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          nfire_d = '0;
          unique case (s_axis_tuser)
            KIND_TICK: begin
              mode_d = MODE_DUE;
              now_d  = now_q + {48'd0, per_q};
            end
            KIND_CANCEL: mode_d = MODE_ID;
            default:     mode_d = MODE_FREE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (kind_q == KIND_TICK) begin
            if (win.valid && (nfire_q != NW'(MAX_FIRES))) begin
              buf_we  = 1'b1;
              op      = OP_FIRE;
              nfire_d = nfire_q + NW'(1);
              cnt_d   = '0;
              if (win.rep) icnt_d = icnt_q + 32'd1;
            end else begin
              more_d = win.valid;
              rd_d   = '0;
              state_d = (nfire_q == '0) ? ST_IDLE : ST_RD;
            end
          end else if (out_free) begin
            out_valid_d = 1'b1;
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
            if (kind_q == KIND_CANCEL) begin
              if (win.valid) begin
                op         = OP_FREE;
                out_user_d = RES_CANCEL;
                out_data_d = {1'b0, win.target, win.tag, cid_q};
              end else begin
                out_user_d = RES_NOTFOUND;
                out_data_d = {1'b0, 64'd0, 16'd0, cid_q};
              end
            end else if (win.valid) begin
              op         = OP_LOAD;
              icnt_d     = icnt_q + 32'd1;
              nid_d      = (nid_inc == 31'd0) ? 31'd1 : nid_inc;
              out_user_d = RES_SCHED;
              out_data_d = {1'b0, ld.target, tag_q, nid_q};
            end else begin
              out_user_d = RES_FULL;
              out_data_d = '0;
            end
          end
        end
      end
      ST_RD: state_d = ST_WR;
      ST_WR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = RES_FIRED;
          out_data_d  = {more_q, rdata_q[63:0], rdata_q[79:64], rdata_q[110:80]};
          out_last_d  = (rd_q + NW'(1) == nfire_q);
          rd_d        = rd_q + NW'(1);
          state_d     = (rd_q + NW'(1) == nfire_q) ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      nfire_q     <= '0;
      rd_q        <= '0;
      more_q      <= 1'b0;
      per_q       <= PERIOD_RESET;
      now_q       <= '0;
      nid_q       <= FIRST_ID;
      icnt_q      <= '0;
      mode_q      <= MODE_DUE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      nfire_q     <= nfire_d;
      rd_q        <= rd_d;
      more_q      <= more_d;
      now_q       <= now_d;
      nid_q       <= nid_d;
      icnt_q      <= icnt_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) per_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= s_axis_tuser;
      delay_q <= s_axis_tdata[31:0];
      tag_q   <= s_axis_tdata[47:32];
      cid_q   <= s_axis_tdata[78:48];
    end
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
    // buffer fires until the tick knows whether any stay due
    if (buf_we) mem[nfire_q[FW-1:0]] <= {win.id, win.tag, win.target};
    rdata_q <= mem[rd_q[FW-1:0]];
  end

`ifndef ASSERT_OFF
  a_op_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op != OP_NONE) |-> scan_done)
    else $error("slot update outside a finished search");
  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfire_q <= NW'(MAX_FIRES))
    else $error("fire count beyond limit");
  a_drain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RD) || (state_q == ST_WR)) |-> (rd_q < nfire_q))
    else $error("drain pointer past buffered fires");
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ((state_q == ST_SCAN) && (cnt_q == '0)))
    else $error("accepted word did not start a search");
`endif

endmodule
